>>> rtl/core/sorted_unique_int_set_top_assert.svh
// Assertion macros for the sorted integer set block.
`ifndef SORTED_UNIQUE_INT_SET_TOP_ASSERT_SVH
`define SORTED_UNIQUE_INT_SET_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define SUSI_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Condition in the same cycle as the trigger.
`define SUSI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/susi_pkg.sv
// Shared types and constants for the sorted integer set block.
package susi_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 10;
  localparam int WHERE_W   = 10;
  localparam int COUNT_W   = 11;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t FULL_COUNT = cnt_t'(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_CONTAINS,
    OP_GET
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_DUPLICATE,
    ST_FULL,
    ST_BAD_INDEX
  } status_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]         index;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic [WHERE_W-1:0]         where;
    logic signed [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]         count;
  } res_t;

  typedef struct packed {
    logic                       we;
    addr_t                      waddr;
    logic signed [VALUE_W-1:0]  wdata;
    addr_t                      raddr;
  } ram_req_t;

endpackage

>>> rtl/core/susi_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module susi_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/susi_ctrl.sv
// Sequencer: binary search, entry shifting and result build over the shared RAM port.
`include "sorted_unique_int_set_top_assert.svh"

module susi_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  susi_pkg::req_t                     req,
  output logic                               res_valid,
  input  logic                               res_ready,
  output susi_pkg::res_t                     res,
  output susi_pkg::ram_req_t                 ram_req,
  input  logic signed [susi_pkg::VALUE_W-1:0] ram_rdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_EXEC,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_GET,
    S_GET_WAIT,
    S_DONE
  } state_t;

  state_t         state;
  susi_pkg::req_t op;
  susi_pkg::cnt_t fill;
  susi_pkg::cnt_t lo;
  susi_pkg::cnt_t hi;
  susi_pkg::cnt_t j;
  logic           hit;

  susi_pkg::cnt_t mid;
  susi_pkg::cnt_t j_dec;
  susi_pkg::cnt_t j_inc;
  logic           idx_ok;

  function automatic susi_pkg::res_t mk_res(susi_pkg::status_t st, susi_pkg::cnt_t w,
                                            logic signed [susi_pkg::VALUE_W-1:0] rv,
                                            susi_pkg::cnt_t c);
    susi_pkg::res_t r;
    r.status     = st;
    r.where      = susi_pkg::WHERE_W'(w);
    r.read_value = rv;
    r.count      = susi_pkg::COUNT_W'(c);
    return r;
  endfunction

  assign mid    = lo + ((hi - lo) >> 1);
  assign j_dec  = j - susi_pkg::cnt_t'(1);
  assign j_inc  = j + susi_pkg::cnt_t'(1);
  assign idx_ok = 32'(op.index) < 32'(fill);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = j[susi_pkg::ADDR_W-1:0];
    ram_req.wdata = ram_rdata;
    ram_req.raddr = mid[susi_pkg::ADDR_W-1:0];
    case (state)
      S_GET: begin
        ram_req.raddr = susi_pkg::addr_t'(op.index);
      end
      S_UP_RD: begin
        if (j == lo) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = lo[susi_pkg::ADDR_W-1:0];
          ram_req.wdata = op.value;
        end else begin
          ram_req.raddr = j_dec[susi_pkg::ADDR_W-1:0];
        end
      end
      S_UP_WR: begin
        ram_req.we = 1'b1;
      end
      S_DN_RD: begin
        ram_req.raddr = j_inc[susi_pkg::ADDR_W-1:0];
      end
      S_DN_WR: begin
        ram_req.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req;
            lo    <= '0;
            hi    <= fill;
            hit   <= 1'b0;
            state <= (req.kind == susi_pkg::OP_GET) ? S_GET : S_PROBE;
          end
        end
        S_PROBE: begin
          state <= (lo < hi) ? S_CMP : S_EXEC;
        end
        S_CMP: begin
          if (ram_rdata == op.value) begin
            hit <= 1'b1;
            lo  <= mid;
            hi  <= mid;
          end else if (ram_rdata < op.value) begin
            lo <= mid + susi_pkg::cnt_t'(1);
          end else begin
            hi <= mid;
          end
          state <= S_PROBE;
        end
        S_EXEC: begin
          case (op.kind)
            susi_pkg::OP_INSERT: begin
              if (hit) begin
                res   <= mk_res(susi_pkg::ST_DUPLICATE, '0, '0, fill);
                state <= S_DONE;
              end else if (fill >= susi_pkg::FULL_COUNT) begin
                res   <= mk_res(susi_pkg::ST_FULL, '0, '0, fill);
                state <= S_DONE;
              end else begin
                j     <= fill;
                state <= S_UP_RD;
              end
            end
            susi_pkg::OP_REMOVE: begin
              if (!hit) begin
                res   <= mk_res(susi_pkg::ST_NOT_FOUND, '0, '0, fill);
                state <= S_DONE;
              end else begin
                j     <= lo;
                state <= S_DN_RD;
              end
            end
            susi_pkg::OP_CONTAINS: begin
              if (hit) begin
                res <= mk_res(susi_pkg::ST_OK, lo, '0, fill);
              end else begin
                res <= mk_res(susi_pkg::ST_NOT_FOUND, '0, '0, fill);
              end
              state <= S_DONE;
            end
            default: begin
              res   <= mk_res(susi_pkg::ST_BAD_INDEX, '0, '0, fill);
              state <= S_DONE;
            end
          endcase
        end
        S_UP_RD: begin
          if (j == lo) begin
            fill  <= fill + susi_pkg::cnt_t'(1);
            res   <= mk_res(susi_pkg::ST_OK, lo, '0, fill + susi_pkg::cnt_t'(1));
            state <= S_DONE;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          j     <= j_dec;
          state <= S_UP_RD;
        end
        S_DN_RD: begin
          if (j_inc >= fill) begin
            fill  <= fill - susi_pkg::cnt_t'(1);
            res   <= mk_res(susi_pkg::ST_OK, lo, '0, fill - susi_pkg::cnt_t'(1));
            state <= S_DONE;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          j     <= j_inc;
          state <= S_DN_RD;
        end
        S_GET: begin
          if (idx_ok) begin
            state <= S_GET_WAIT;
          end else begin
            res   <= mk_res(susi_pkg::ST_BAD_INDEX, '0, '0, fill);
            state <= S_DONE;
          end
        end
        S_GET_WAIT: begin
          res   <= mk_res(susi_pkg::ST_OK, '0, ram_rdata, fill);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SUSI_ASSERT_ALWAYS(a_fill_bound, fill <= susi_pkg::FULL_COUNT)
  `SUSI_ASSERT_IMPL(a_fill_on_done, !$past(rst) && (fill != $past(fill)), state == S_DONE)
  `SUSI_ASSERT_IMPL(a_hit_in_range, hit && (state == S_EXEC), lo < fill)
  `SUSI_ASSERT_IMPL(a_up_above_pos, state == S_UP_WR, j > lo)

endmodule

>>> rtl/core/sorted_unique_int_set_top.sv
// Top level of the sorted integer set: stream ports, output register, RAM and sequencer.
// Accept to m_tvalid: a get reads the indexed entry (a bad index skips the read);
//   other kinds run the search probes (up to log2(fill)+1 probes), then shift entries
//   on a successful insert or remove; the output register then takes the result.
// Throughput: one item at a time; s_tready returns once the result is registered.
// Reset: fill count cleared at once; RAM contents are not cleared and need no pass.
module sorted_unique_int_set_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // value[31:0], index[41:32], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // where[9:0], read_value[41:10], count[52:42], zero pad
  output logic [2:0]  m_tuser    // status[2:0]
);

  susi_pkg::req_t     req;
  susi_pkg::res_t     res;
  susi_pkg::res_t     out_res;
  susi_pkg::ram_req_t ram_req;
  logic               res_valid;
  logic               res_ready;
  logic signed [susi_pkg::VALUE_W-1:0] ram_rdata;

  assign req.kind  = susi_pkg::kind_t'(s_tuser);
  assign req.value = s_tdata[31:0];
  assign req.index = s_tdata[41:32];

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
        out_res  <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {3'b000, out_res.count, out_res.read_value, out_res.where};
  assign m_tuser = out_res.status;

  susi_ram #(
    .DEPTH(susi_pkg::CAPACITY),
    .WIDTH(susi_pkg::VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  susi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule
